@@ sv/teq_pkg.sv @@
// ----------------------------------------------------------------------------
// teq_pkg: shared types and constants of the timestamped event queue
// Holds the entry layout, the operation codes and the control struct that
// the top level broadcasts along the row of cells.
// ----------------------------------------------------------------------------
package teq_pkg;

    // Operation codes carried in the mode field of an input beat
    localparam logic [1:0] MODE_PUSH    = 2'd0;
    localparam logic [1:0] MODE_COMPACT = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;

    // Largest sample offset that an entry can hold
    localparam logic [29:0] OFFSET_MAX = 30'h3fff_ffff;

    // One queued event
    typedef struct packed {
        logic [29:0] offset;
        logic [1:0]  kind;
        logic [31:0] payload;
    } t_entry;

    // What every cell does at the next edge
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT
    } t_cell_op;

    // Broadcast to all cells
    typedef struct packed {
        t_cell_op op;
        logic     wr_en;
        t_entry   entry;
    } t_cell_ctl;

endpackage

@@ sv/teq_if.sv @@
// ----------------------------------------------------------------------------
// teq_in_if / teq_out_if: valid-ready channels of the event queue
// One beat moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface teq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] arrival_offset;
    logic [1:0]  event_kind;
    logic [31:0] event_payload;
    logic [15:0] rendered_frames;
    logic [5:0]  first_pending;
    logic [4:0]  read_index;

    modport source (
        output valid, mode, arrival_offset, event_kind, event_payload,
               rendered_frames, first_pending, read_index,
        input  ready
    );
    modport sink (
        input  valid, mode, arrival_offset, event_kind, event_payload,
               rendered_frames, first_pending, read_index,
        output ready
    );
endinterface

interface teq_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [5:0]  entry_count;
    logic        entry_valid;
    logic [29:0] entry_offset;
    logic [1:0]  entry_kind;
    logic [31:0] entry_payload;

    modport source (
        output valid, accepted, entry_count, entry_valid, entry_offset,
               entry_kind, entry_payload,
        input  ready
    );
    modport sink (
        input  valid, accepted, entry_count, entry_valid, entry_offset,
               entry_kind, entry_payload,
        output ready
    );
endinterface

@@ sv/teq_cell.sv @@
// ----------------------------------------------------------------------------
// teq_cell: one slot of the sorted event row
// Holds one entry and picks its next value from itself, its neighbours or
// the broadcast entry, as the broadcast operation says.
// ----------------------------------------------------------------------------
module teq_cell
    import teq_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int INDEX = 0,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int PTR_W = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [CNT_W-1:0] i_count,
    input  logic [PTR_W-1:0] i_wptr,
    input  logic             i_le_prev,
    input  t_entry           i_left,
    input  t_entry           i_right,
    output logic             o_le,
    output t_entry           o_entry
);

    t_entry r_ent;
    t_entry n_ent;
    logic   w_valid;

    // Flag a stored entry that sorts at or before the incoming one
    assign w_valid = CNT_W'(INDEX) < i_count;
    assign o_le    = w_valid && (r_ent.offset <= i_ctl.entry.offset);
    assign o_entry = r_ent;

    // Select the next entry
    always_comb begin
        n_ent = r_ent;
        case (i_ctl.op)
            OP_INSERT: begin
                if (o_le) begin
                    n_ent = r_ent;
                end else if (i_le_prev) begin
                    n_ent = i_ctl.entry;
                end else begin
                    n_ent = i_left;
                end
            end
            OP_SHIFT: begin
                if (i_ctl.wr_en && (i_wptr == PTR_W'(INDEX))) begin
                    n_ent = i_ctl.entry;
                end else begin
                    n_ent = i_right;
                end
            end
            default: n_ent = r_ent;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

endmodule

@@ sv/timestamped_event_queue.sv @@
// ----------------------------------------------------------------------------
// timestamped_event_queue: bounded queue of events sorted by sample offset
// Usage:
//   i_evt carries one operation per beat: push an event, compact after a
//   render, or read the entry at a sorted position. o_res returns exactly one
//   result beat per operation, carrying the entry count afterwards.
//   Push and read results are registered at the edge that takes the beat, and
//   the next beat may follow in the next cycle.
//   Compact walks the row of cells from the head, one entry per cycle; its
//   result appears at the end of the walk and no new beat is taken
//   meanwhile. The walk sets the rate of compact.
//   Pushes equal to a stored offset go behind it; a push to a full queue is
//   dropped and reported with accepted low.
//   Reset empties the queue and drops any pending result; the stored slots
//   need no clearing, as only slots below the count are ever read.
//   When the receiver stalls, the result waits in the output register and
//   one further beat is taken only once that result moves.
// ----------------------------------------------------------------------------
module timestamped_event_queue
    import teq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    teq_in_if.sink    i_evt,
    teq_out_if.source o_res
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int RD_N  = (QUEUE_DEPTH < 32) ? QUEUE_DEPTH : 32;

    typedef enum logic [1:0] {
        S_IDLE    = 2'b01,
        S_COMPACT = 2'b10
    } t_state;

    typedef struct packed {
        logic        accepted;
        logic [5:0]  entry_count;
        logic        entry_valid;
        logic [29:0] entry_offset;
        logic [1:0]  entry_kind;
        logic [31:0] entry_payload;
    } t_result;

    t_state           r_state,     n_state;
    logic [CNT_W-1:0] r_count,     n_count;
    logic [CNT_W-1:0] r_left,      n_left;
    logic [CNT_W-1:0] r_step,      n_step;
    logic [CNT_W-1:0] r_wr,        n_wr;
    logic [PTR_W-1:0] r_wptr,      n_wptr;
    logic [15:0]      r_frames,    n_frames;
    logic [5:0]       r_first,     n_first;
    logic             r_out_valid, n_out_valid;
    t_result          r_res,       n_res;

    t_cell_ctl        w_ctl;
    t_entry           w_ent [QUEUE_DEPTH];
    logic             w_le  [QUEUE_DEPTH];
    t_entry           w_new;
    t_entry           w_head;
    t_entry           w_rd;
    logic             w_in_fire;
    logic             w_out_fire;
    logic             w_full;
    logic             w_survive;

    // Handshakes
    assign i_evt.ready = (r_state == S_IDLE) && (!r_out_valid || o_res.ready);
    assign w_in_fire   = i_evt.valid && i_evt.ready;
    assign w_out_fire  = r_out_valid && o_res.ready;
    assign w_full      = r_count == CNT_W'(QUEUE_DEPTH);

    // Saturate the pushed offset
    always_comb begin
        w_new.offset  = (|i_evt.arrival_offset[31:30]) ? OFFSET_MAX
                                                       : i_evt.arrival_offset[29:0];
        w_new.kind    = i_evt.event_kind;
        w_new.payload = i_evt.event_payload;
    end

    // Judge the head entry during a compact walk
    always_comb begin
        w_survive = (32'(r_step) >= 32'(r_first))
                 && (w_ent[0].offset >= 30'(r_frames));
        w_head         = w_ent[0];
        w_head.offset  = w_ent[0].offset - 30'(r_frames);
    end

    // Select the entry to read
    always_comb begin
        w_rd = w_ent[0];
        for (int j = 0; j < RD_N; j++) begin
            if (i_evt.read_index == 5'(j)) begin
                w_rd = w_ent[j];
            end
        end
    end

    // Drive the cell row
    always_comb begin
        w_ctl.op    = OP_HOLD;
        w_ctl.wr_en = 1'b0;
        w_ctl.entry = w_new;
        if ((r_state == S_COMPACT) && (r_left != '0)) begin
            w_ctl.op    = OP_SHIFT;
            w_ctl.wr_en = w_survive;
            w_ctl.entry = w_head;
        end else if (w_in_fire && (i_evt.mode == MODE_PUSH) && !w_full) begin
            w_ctl.op = OP_INSERT;
        end
    end

    // Row of cells
    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        teq_cell #(
            .DEPTH (QUEUE_DEPTH),
            .INDEX (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_count   (r_count),
            .i_wptr    (r_wptr),
            .i_le_prev ((k == 0) ? 1'b1 : w_le[(k == 0) ? 0 : k - 1]),
            .i_left    (w_ent[(k == 0) ? 0 : k - 1]),
            .i_right   (w_ent[(k == QUEUE_DEPTH - 1) ? k : k + 1]),
            .o_le      (w_le[k]),
            .o_entry   (w_ent[k])
        );
    end

    // Sequence operations and build results
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_step      = r_step;
        n_wr        = r_wr;
        n_wptr      = r_wptr;
        n_frames    = r_frames;
        n_first     = r_first;
        n_out_valid = r_out_valid && !w_out_fire;
        n_res       = r_res;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_res       = '0;
                    n_out_valid = 1'b1;
                    case (i_evt.mode)
                        MODE_PUSH: begin
                            if (!w_full) begin
                                n_count        = r_count + CNT_W'(1);
                                n_res.accepted = 1'b1;
                            end
                        end
                        MODE_COMPACT: begin
                            n_out_valid = 1'b0;
                            n_state     = S_COMPACT;
                            n_left      = r_count;
                            n_step      = '0;
                            n_wr        = '0;
                            n_wptr      = PTR_W'(r_count - CNT_W'(1));
                            n_frames    = i_evt.rendered_frames;
                            n_first     = i_evt.first_pending;
                        end
                        MODE_READ: begin
                            if (32'(i_evt.read_index) < 32'(r_count)) begin
                                n_res.entry_valid   = 1'b1;
                                n_res.entry_offset  = w_rd.offset;
                                n_res.entry_kind    = w_rd.kind;
                                n_res.entry_payload = w_rd.payload;
                            end
                        end
                        default: n_res = '0;
                    endcase
                    n_res.entry_count = 6'(n_count);
                end
            end
            S_COMPACT: begin
                if (r_left == '0) begin
                    n_count           = r_wr;
                    n_res             = '0;
                    n_res.entry_count = 6'(r_wr);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    n_left = r_left - CNT_W'(1);
                    n_step = r_step + CNT_W'(1);
                    if (w_survive) begin
                        n_wr = r_wr + CNT_W'(1);
                    end else begin
                        n_wptr = r_wptr - PTR_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Walk and result registers
    always_ff @(posedge i_clk) begin
        r_left   <= n_left;
        r_step   <= n_step;
        r_wr     <= n_wr;
        r_wptr   <= n_wptr;
        r_frames <= n_frames;
        r_first  <= n_first;
        r_res    <= n_res;
    end

    // Result beat
    assign o_res.valid         = r_out_valid;
    assign o_res.accepted      = r_res.accepted;
    assign o_res.entry_count   = r_res.entry_count;
    assign o_res.entry_valid   = r_res.entry_valid;
    assign o_res.entry_offset  = r_res.entry_offset;
    assign o_res.entry_kind    = r_res.entry_kind;
    assign o_res.entry_payload = r_res.entry_payload;

endmodule
